### hdl/sid_pkg.sv
// Shared types and constants for the signed 32-bit saturating divider.
`default_nettype none

package sid_pkg;

  // Operand and quotient word width.
  localparam int unsigned WordW = 32;

  // One division cell per quotient bit.
  localparam int unsigned NumCells = WordW;

  // Largest positive quotient; also the answer for a zero divisor.
  localparam logic [WordW-1:0] QuotMax = 32'h7fff_ffff;

  // Partial division state that moves from one cell to the next.
  typedef struct packed {
    logic [WordW-1:0] rem;  // partial remainder
    logic [WordW-1:0] nq;   // dividend bits still to shift in, quotient bits in the low end
    logic [WordW-1:0] den;  // divisor magnitude
    logic             neg;  // result is negative
    logic             dz;   // divisor was zero
  } stage_t;

endpackage

`default_nettype wire

### hdl/sid_in_if.sv
// Operand channel: dividend and divisor with a valid/ready handshake.
`default_nettype none

interface sid_in_if;
  import sid_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [WordW-1:0] numerator;
  logic signed [WordW-1:0] denominator;

  modport source (output valid, output numerator, output denominator, input ready);
  modport sink   (input valid, input numerator, input denominator, output ready);

endinterface

`default_nettype wire

### hdl/sid_out_if.sv
// Result channel: quotient and status flags with a valid/ready handshake.
`default_nettype none

interface sid_out_if;
  import sid_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [WordW-1:0] quotient;
  logic                    overflowed;
  logic                    by_zero;

  modport source (output valid, output quotient, output overflowed, output by_zero,
                  input ready);
  modport sink   (input valid, input quotient, input overflowed, input by_zero,
                  output ready);

endinterface

`default_nettype wire

### hdl/sid_cell.sv
// One restoring-division cell: forms one quotient bit and passes the state on.
`default_nettype none

module sid_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  sid_pkg::stage_t stage_i,
  output logic            valid_o,
  output sid_pkg::stage_t stage_o
);
  import sid_pkg::*;

  logic [WordW:0]   rem_sh;
  logic [WordW:0]   rem_sub;
  logic             take;
  stage_t           stage_d;
  stage_t           stage_q;
  logic             valid_q;

  // Shift the next dividend bit into the remainder and try the subtraction.
  always_comb begin
    rem_sh  = {stage_i.rem, stage_i.nq[WordW-1]};
    rem_sub = rem_sh - {1'b0, stage_i.den};
    take    = (rem_sh >= {1'b0, stage_i.den});
    stage_d = stage_i;
    stage_d.rem = take ? rem_sub[WordW-1:0] : rem_sh[WordW-1:0];
    stage_d.nq  = {stage_i.nq[WordW-2:0], take};
  end

  // The beat valid flag is control state and gets reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  // Payload register.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stage_q <= stage_d;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule

`default_nettype wire

### hdl/signed_int32_divider_saturating.sv
// Top level of the signed 32-bit divider with saturation and divide-by-zero flag.
`default_nettype none

// Signed 32-bit divider, quotient truncated toward zero. Each beat goes through
// one operand register (magnitudes and sign), a row of 32 division cells that
// each produce one quotient bit, and one result register: 34 registers in a
// row between an accepted input beat and its result. The row is fully
// pipelined: a new operand beat is taken every cycle while the result register
// is free or being read, and the whole row stalls while a result waits. A zero
// divisor returns 2147483647 with by_zero set; -2147483648 / -1 returns
// 2147483647 with overflowed set.
module signed_int32_divider_saturating (
  input  logic  clk_i,
  input  logic  rst_ni,
  sid_in_if.sink    in_i,
  sid_out_if.source out_o
);
  import sid_pkg::*;

  logic                    en;
  stage_t                  chain   [NumCells+1];
  logic                    chain_v [NumCells+1];
  stage_t                  prep_d;
  logic [WordW-1:0]        num_u;
  logic [WordW-1:0]        den_u;
  logic [WordW-1:0]        q_mag;
  logic [WordW-1:0]        q_neg;
  logic                    out_valid_q;
  logic [WordW-1:0]        quotient_q;
  logic [WordW-1:0]        quotient_d;
  logic                    ovf_q;
  logic                    ovf_d;
  logic                    dz_q;
  logic                    dz_d;

  // The whole row advances unless a result is held and not being read.
  assign en        = !out_valid_q || out_o.ready;
  assign in_i.ready = en;

  // Operand preparation: magnitudes, result sign and zero-divisor check.
  always_comb begin
    num_u       = in_i.numerator;
    den_u       = in_i.denominator;
    prep_d.rem  = '0;
    prep_d.nq   = num_u[WordW-1] ? (~num_u + 1'b1) : num_u;
    prep_d.den  = den_u[WordW-1] ? (~den_u + 1'b1) : den_u;
    prep_d.neg  = num_u[WordW-1] ^ den_u[WordW-1];
    prep_d.dz   = (den_u == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_v[0] <= 1'b0;
    end else if (en) begin
      chain_v[0] <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      chain[0] <= prep_d;
    end
  end

  // Row of division cells, most significant quotient bit first.
  for (genvar g = 0; g < NumCells; g++) begin : g_cell
    sid_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (chain_v[g]),
      .stage_i (chain[g]),
      .valid_o (chain_v[g+1]),
      .stage_o (chain[g+1])
    );
  end

  // Sign fix-up and saturation.
  always_comb begin
    q_mag      = chain[NumCells].nq;
    q_neg      = ~q_mag + 1'b1;
    quotient_d = q_mag;
    ovf_d      = 1'b0;
    dz_d       = 1'b0;
    if (chain[NumCells].dz) begin
      quotient_d = QuotMax;
      dz_d       = 1'b1;
    end else if (chain[NumCells].neg) begin
      quotient_d = q_neg;
    end else if (q_mag[WordW-1]) begin
      quotient_d = QuotMax;
      ovf_d      = 1'b1;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= chain_v[NumCells];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      quotient_q <= quotient_d;
      ovf_q      <= ovf_d;
      dz_q       <= dz_d;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.quotient   = quotient_q;
  assign out_o.overflowed = ovf_q;
  assign out_o.by_zero    = dz_q;

  // The two status flags never appear on the same beat.
  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> !(out_o.overflowed && out_o.by_zero))
    else $error("overflow and divide-by-zero flagged together");

  // A flagged beat always carries the saturated quotient.
  a_flag_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (out_o.overflowed || out_o.by_zero)) |-> (quotient_q == QuotMax))
    else $error("flagged result is not saturated");

  // With no result held, the operand side is always open.
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_o.valid |-> in_i.ready)
    else $error("input stalled with an empty result register");

  // A stalled result keeps its row frozen: the last cell does not move.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.ready) |=> $stable(chain_v[NumCells]))
    else $error("division row moved during a stall");

endmodule

`default_nettype wire

### tb/sv/tb_signed_int32_divider_saturating.sv
// Testbench for the signed 32-bit saturating divider: queued stimulus, predicted quotients.
module tb_signed_int32_divider_saturating;
  import sid_pkg::*;

  // Operand pair held until the driver sends it.
  typedef struct packed {
    logic [WordW-1:0] num;
    logic [WordW-1:0] den;
  } operand_pair_t;

  // Predicted fields of one result beat.
  typedef struct packed {
    logic [WordW-1:0] quotient;
    logic             overflowed;
    logic             by_zero;
  } quot_result_t;

  localparam logic [WordW-1:0] MinWord   = 32'h8000_0000;
  localparam logic [WordW-1:0] MinusOne  = 32'hffff_ffff;
  localparam int               NumRandom = 2000;
  localparam int               IdlePct   = 26;
  localparam int               QuietLo   = 700;
  localparam int               QuietHi   = 1100;
  localparam int               StallLimit = 2000;
  localparam int               DrainCycles = 40;

  logic clk_i;
  logic rst_ni;

  sid_in_if  op_if ();
  sid_out_if res_if ();

  signed_int32_divider_saturating dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (op_if),
    .out_o  (res_if)
  );

  operand_pair_t pending_ops[$];
  quot_result_t  quotient_fifo[$];
  int            error_count;
  int            ops_accepted;
  int            results_seen;
  int            stall_cycles;

  // Truncating signed division with saturation and a divide-by-zero answer.
  function automatic quot_result_t divide_saturate(logic [WordW-1:0] num,
                                                   logic [WordW-1:0] den);
    logic [WordW-1:0] num_mag;
    logic [WordW-1:0] den_mag;
    logic [WordW-1:0] q_mag;
    quot_result_t     r;
    num_mag = num[WordW-1] ? (~num + 1'b1) : num;
    den_mag = den[WordW-1] ? (~den + 1'b1) : den;
    r = '0;
    if (den_mag == '0) begin
      r.quotient = QuotMax;
      r.by_zero  = 1'b1;
    end else begin
      q_mag = num_mag / den_mag;
      if (num[WordW-1] != den[WordW-1]) begin
        r.quotient = ~q_mag + 1'b1;
      end else if (q_mag > QuotMax) begin
        r.quotient   = QuotMax;
        r.overflowed = 1'b1;
      end else begin
        r.quotient = q_mag;
      end
    end
    return r;
  endfunction

  task automatic flag_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $time, what);
    error_count++;
  endtask

  task automatic queue_op(input logic [WordW-1:0] num, input logic [WordW-1:0] den);
    operand_pair_t p;
    p.num = num;
    p.den = den;
    pending_ops.push_back(p);
  endtask

  // Clock and a single reset at the start.
  initial begin
    clk_i  = 1'b0;
    rst_ni = 1'b0;
    fork
      forever #5 clk_i = ~clk_i;
      begin
        repeat (3) @(posedge clk_i);
        rst_ni <= 1'b1;
      end
    join_none
  end

  // Known values on every block input before the first edge.
  initial begin
    op_if.valid       = 1'b0;
    op_if.numerator   = '0;
    op_if.denominator = '0;
    res_if.ready      = 1'b0;
  end

  // Operand driver: holds a beat until it is taken, predicts on acceptance.
  always @(posedge clk_i or negedge rst_ni) begin
    operand_pair_t p;
    bit            quiet;
    if (!rst_ni) begin
      op_if.valid <= 1'b0;
    end else begin
      if (op_if.valid && op_if.ready) begin
        quotient_fifo.push_back(divide_saturate(op_if.numerator, op_if.denominator));
        ops_accepted++;
      end
      if (!op_if.valid || op_if.ready) begin
        quiet = (ops_accepted >= QuietLo) && (ops_accepted < QuietHi);
        if (pending_ops.size() > 0 && (quiet || $urandom_range(0, 99) >= IdlePct)) begin
          p = pending_ops.pop_front();
          op_if.valid       <= 1'b1;
          op_if.numerator   <= p.num;
          op_if.denominator <= p.den;
        end else begin
          op_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: random backpressure and a field-by-field compare.
  always @(posedge clk_i or negedge rst_ni) begin
    quot_result_t want;
    bit           quiet;
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        results_seen++;
        if (quotient_fifo.size() == 0) begin
          flag_mismatch($sformatf("unexpected result beat, quotient %h", res_if.quotient));
        end else begin
          want = quotient_fifo.pop_front();
          if (res_if.quotient !== want.quotient)
            flag_mismatch($sformatf("quotient %h, predicted %h",
                                    res_if.quotient, want.quotient));
          if (res_if.overflowed !== want.overflowed)
            flag_mismatch($sformatf("overflowed %b, predicted %b",
                                    res_if.overflowed, want.overflowed));
          if (res_if.by_zero !== want.by_zero)
            flag_mismatch($sformatf("by_zero %b, predicted %b",
                                    res_if.by_zero, want.by_zero));
        end
      end
      quiet = (results_seen >= QuietLo) && (results_seen < QuietHi);
      res_if.ready <= quiet || ($urandom_range(0, 99) >= IdlePct);
    end
  end

  // Watchdog on cycles in which no beat moves on either side.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((op_if.valid && op_if.ready) || (res_if.valid && res_if.ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= StallLimit) begin
        $display("Verification failed");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // Stimulus: directed corner cases, then a random mix, then the end check.
  initial begin
    int          sel;
    logic [31:0] num;
    logic [31:0] den;
    error_count  = 0;
    ops_accepted = 0;
    results_seen = 0;
    stall_cycles = 0;

    queue_op(32'd0, 32'd1);
    queue_op(32'd1, 32'd1);
    queue_op(MinusOne, 32'd1);
    queue_op(MinWord, 32'd1);
    queue_op(MinWord, MinusOne);
    queue_op(MinWord, MinWord);
    queue_op(QuotMax, QuotMax);
    queue_op(QuotMax, MinusOne);
    queue_op(QuotMax, 32'd1);
    queue_op(MinWord, 32'd0);
    queue_op(32'd0, 32'd0);
    queue_op(QuotMax, 32'd0);
    queue_op(-32'sd5, 32'd0);
    queue_op(32'd7, 32'd2);
    queue_op(-32'sd7, 32'd2);
    queue_op(32'd7, -32'sd2);
    queue_op(-32'sd7, -32'sd2);
    queue_op(32'd1, MinWord);
    queue_op(QuotMax, MinWord);
    queue_op(MinWord, QuotMax);
    queue_op(MinWord, 32'd2);
    queue_op(32'd5, 32'd7);
    queue_op(32'hffff_ffff, 32'hffff_ffff);
    queue_op(32'haaaa_aaaa, 32'h5555_5555);

    for (int i = 0; i < NumRandom; i++) begin
      sel = $urandom_range(0, 99);
      num = $urandom();
      den = $urandom();
      if (sel < 55) begin
        // Full-width random operands.
      end else if (sel < 75) begin
        den = 32'(int'($urandom_range(0, 600)) - 300);
      end else if (sel < 83) begin
        den = '0;
      end else if (sel < 88) begin
        num = MinWord;
        den = MinusOne;
      end else if (sel < 93) begin
        num = $urandom_range(0, 1) ? MinWord : QuotMax;
        if ($urandom_range(0, 1)) den = 32'(int'($urandom_range(0, 8)) - 4);
      end else begin
        num = 32'(int'($urandom_range(0, 2000)) - 1000);
        den = 32'(int'($urandom_range(0, 40)) - 20);
      end
      queue_op(num, den);
    end

    // Drain: everything sent, every prediction matched, then a short settle.
    while (pending_ops.size() > 0 || op_if.valid) @(posedge clk_i);
    while (quotient_fifo.size() > 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
